### design/fedf_pkg.sv
package fedf_pkg;

    localparam int unsigned LEN_BITS_DEF = 16;

    localparam logic [7:0] FLAG_BYTE = 8'h7E;
    localparam logic [7:0] ESC_BYTE  = 8'h7D;
    localparam logic [7:0] ESC_FLAG  = 8'h5E;
    localparam logic [7:0] ESC_ESC   = 8'h5D;

    localparam logic [7:0]  MIN_LEN_RESET = 8'd2;
    localparam logic [15:0] FRAME_LEN_MAX = 16'hFFFF;

    typedef enum logic [1:0] {
        MODE_HUNT  = 2'd0,
        MODE_FRAME = 2'd1,
        MODE_ESC   = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_SHORT     = 2'd1,
        STATUS_BAD_ESC   = 2'd2
    } t_status;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        is_end;
        t_status     frame_status;
        logic [15:0] frame_len;
    } t_result;

endpackage

### design/fedf_in_reg.sv
module fedf_in_reg (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,
    input  logic       i_advance,
    output logic       o_valid,
    output logic [7:0] o_byte
);

    logic       r_valid;
    logic [7:0] r_byte;
    logic       n_valid;

    // The held byte leaves whenever the decoder can hand its result on.
    assign s_axis_tready = !r_valid || i_advance;

    always_comb begin
        n_valid = r_valid;
        if (s_axis_tready) begin
            n_valid = s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_byte <= s_axis_tdata;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;

endmodule

### design/fedf_decode.sv
module fedf_decode #(
    parameter int unsigned LEN_BITS = fedf_pkg::LEN_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [7:0]       i_cfg_data,
    input  logic             i_valid,
    input  logic [7:0]       i_byte,
    input  logic             i_advance,
    output logic             o_res_valid,
    output fedf_pkg::t_result o_res
);

    localparam int unsigned EXT_BITS = (LEN_BITS > 16) ? LEN_BITS : 16;
    localparam logic [LEN_BITS-1:0] COUNT_MAX = {LEN_BITS{1'b1}};

    fedf_pkg::t_mode   r_mode;
    fedf_pkg::t_mode   n_mode;
    logic              r_esc_err;
    logic              n_esc_err;
    logic [LEN_BITS-1:0] r_count;
    logic [LEN_BITS-1:0] n_count;
    logic [7:0]        r_min_len;
    logic              take;
    logic              put;
    logic [7:0]        put_byte;
    logic [EXT_BITS-1:0] count_ext;
    logic [LEN_BITS-1:0] count_inc;

    assign o_cfg_ready = 1'b1;
    assign take        = i_valid && i_advance;
    assign count_ext   = EXT_BITS'(r_count);
    assign count_inc   = (r_count == COUNT_MAX) ? r_count : r_count + 1'b1;

    always_comb begin
        n_mode      = r_mode;
        n_esc_err   = r_esc_err;
        n_count     = r_count;
        o_res_valid = 1'b0;
        o_res       = '0;
        put         = 1'b0;
        put_byte    = i_byte;
        if (take) begin
            unique case (r_mode)
                fedf_pkg::MODE_FRAME, fedf_pkg::MODE_ESC: begin
                    if (i_byte == fedf_pkg::FLAG_BYTE) begin
                        o_res_valid   = 1'b1;
                        o_res.is_end  = 1'b1;
                        if (r_esc_err) begin
                            o_res.frame_status = fedf_pkg::STATUS_BAD_ESC;
                        end else if (count_ext < EXT_BITS'(r_min_len)) begin
                            o_res.frame_status = fedf_pkg::STATUS_SHORT;
                        end else begin
                            o_res.frame_status = fedf_pkg::STATUS_OK;
                        end
                        o_res.frame_len = (count_ext > EXT_BITS'(fedf_pkg::FRAME_LEN_MAX))
                                        ? fedf_pkg::FRAME_LEN_MAX : count_ext[15:0];
                        n_mode    = fedf_pkg::MODE_HUNT;
                        n_esc_err = 1'b0;
                        n_count   = '0;
                    end else if (r_esc_err) begin
                        n_mode = fedf_pkg::MODE_FRAME;
                    end else if (r_mode == fedf_pkg::MODE_ESC) begin
                        n_mode = fedf_pkg::MODE_FRAME;
                        if (i_byte == fedf_pkg::ESC_FLAG) begin
                            put      = 1'b1;
                            put_byte = fedf_pkg::FLAG_BYTE;
                        end else if (i_byte == fedf_pkg::ESC_ESC) begin
                            put      = 1'b1;
                            put_byte = fedf_pkg::ESC_BYTE;
                        end else begin
                            n_esc_err = 1'b1;
                        end
                    end else if (i_byte == fedf_pkg::ESC_BYTE) begin
                        n_mode = fedf_pkg::MODE_ESC;
                    end else begin
                        put = 1'b1;
                    end
                end
                default: begin
                    // Hunting, and the unused code behaves the same.
                    if (i_byte == fedf_pkg::FLAG_BYTE) begin
                        n_mode    = fedf_pkg::MODE_FRAME;
                        n_esc_err = 1'b0;
                        n_count   = '0;
                    end
                end
            endcase
            if (put) begin
                o_res_valid     = 1'b1;
                o_res.data_byte = put_byte;
                n_count         = count_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= fedf_pkg::MODE_HUNT;
            r_esc_err <= 1'b0;
            r_count   <= '0;
            r_min_len <= fedf_pkg::MIN_LEN_RESET;
        end else begin
            r_mode    <= n_mode;
            r_esc_err <= n_esc_err;
            r_count   <= n_count;
            if (i_cfg_valid) begin
                r_min_len <= i_cfg_data;
            end
        end
    end

    a_data_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && !o_res.is_end) |->
            (o_res.frame_status == fedf_pkg::STATUS_OK && o_res.frame_len == '0))
        else $error("data result carries end fields");

    a_end_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.is_end) |=>
            (r_mode == fedf_pkg::MODE_HUNT && r_count == '0 && !r_esc_err))
        else $error("frame close did not return to hunting");

    a_hunt_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == fedf_pkg::MODE_HUNT) |-> (r_count == '0 && !r_esc_err))
        else $error("hunting with frame state left over");

    a_err_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_esc_err |-> (r_mode == fedf_pkg::MODE_FRAME))
        else $error("escape error outside a frame");

endmodule

### design/fedf_out_reg.sv
module fedf_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_res_valid,
    input  fedf_pkg::t_result i_res,
    output logic              o_advance,
    output logic              o_valid,
    output fedf_pkg::t_result o_res,
    input  logic              i_ready
);

    logic              r_valid;
    fedf_pkg::t_result r_res;
    logic              n_valid;

    // A new result may enter while the held one is taken in the same cycle.
    assign o_advance = !r_valid || i_ready;

    always_comb begin
        n_valid = r_valid;
        if (o_advance) begin
            n_valid = i_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance && i_res_valid) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

### design/flag_escape_byte_deframer_top.sv
// Data path: a byte accepted into the input register is decoded combinationally,
// and its result reaches the master side from the result register.
// Throughput: one byte per cycle while the master side takes results; bytes that
// give no result still pass the decode stage with its single state update per beat.
// Reset (i_rst_n low, synchronous): hunting for a flag, count and error cleared,
// min_frame_len back to 2, both stages empty.
module flag_escape_byte_deframer_top #(
    parameter int unsigned LEN_BITS = fedf_pkg::LEN_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data,     // min_frame_len
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [7:0] data_byte, [9:8] frame_status,
                                        // [25:10] frame_len, [31:26] zero
    output logic        m_axis_tlast    // is_end
);

    logic              in_valid;
    logic [7:0]        in_byte;
    logic              advance;
    logic              res_valid;
    fedf_pkg::t_result res;
    fedf_pkg::t_result out_res;

    fedf_in_reg u_in_reg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .i_advance     (advance),
        .o_valid       (in_valid),
        .o_byte        (in_byte)
    );

    fedf_decode #(
        .LEN_BITS (LEN_BITS)
    ) u_decode (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (in_valid),
        .i_byte      (in_byte),
        .i_advance   (advance),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    fedf_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (res_valid),
        .i_res       (res),
        .o_advance   (advance),
        .o_valid     (m_axis_tvalid),
        .o_res       (out_res),
        .i_ready     (m_axis_tready)
    );

    assign m_axis_tdata = {6'd0, out_res.frame_len, out_res.frame_status, out_res.data_byte};
    assign m_axis_tlast = out_res.is_end;

endmodule
